// ----- hw/rtl/vnth_pkg.sv -----
// vnth_pkg: shared constants, types and table builders for the value noise
// terrain height pipeline. Used by vnth_lattice, vnth_hash, vnth_octave and the top.
// No dependencies.
package vnth_pkg;

  // block configuration
  localparam int CHUNK_SIZE     = 16;
  localparam int OCTAVE_LIMIT   = 8;
  localparam int FRAC_BITS      = 16;
  localparam int COS_TABLE_BITS = 8;

  localparam int OCT_N     = OCTAVE_LIMIT - 1;
  localparam int ZOOM_DEN  = 380;
  localparam int ROM_SIZE  = 1 << COS_TABLE_BITS;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  // field widths
  localparam int LOCAL_W  = 4;
  localparam int TILE_W   = 16;
  localparam int SEED_W   = 32;
  localparam int WATER_W  = 8;
  localparam int HEIGHT_W = 10;
  localparam int HEIGHT_MAX = 1023;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATER = 1'd1;

  // world coordinate and lattice widths
  localparam int WU_W = $clog2(32767 * CHUNK_SIZE + 16);
  localparam int WX_W = WU_W + 1;
  localparam int QW   = WU_W - 8;
  localparam int RW   = 9;
  localparam int IX_W = QW + OCT_N - 1;

  // exact reciprocal of the zoom denominator for the world coordinate
  localparam int SH0  = WU_W + RW;
  localparam int M0_W = WU_W + 1;
  localparam int P0_W = WU_W + M0_W;
  localparam longint M0 = ((longint'(1) <<< SH0) + longint'(ZOOM_DEN - 1)) /
                          longint'(ZOOM_DEN);

  // exact reciprocal for the fraction (remainder scaled by 2^FRAC_BITS)
  localparam int SHF  = FRAC_BITS + 2 * RW;
  localparam int MF_W = FRAC_BITS + 10;
  localparam int PF_W = RW + FRAC_BITS + MF_W;
  localparam longint MF = ((longint'(1) <<< SHF) + longint'(ZOOM_DEN - 1)) /
                          longint'(ZOOM_DEN);

  // noise value and accumulation widths
  localparam int VAL_W  = FRAC_BITS + 2;
  localparam int TERM_W = FRAC_BITS + 2;
  localparam int TOT_W  = FRAC_BITS + 3 + $clog2(OCTAVE_LIMIT);
  localparam int NP     = (OCT_N + 1) / 2;

  // lattice hash constants
  localparam int HASH_SHIFT = 13;
  localparam logic [31:0] ROW_STRIDE = 32'd57;
  localparam logic [31:0] HASH_MUL   = 32'd60493;
  localparam logic [31:0] HASH_ADD1  = 32'd19990303;
  localparam logic [31:0] HASH_ADD2  = 32'd1376312589;
  localparam logic [31:0] CORNER_OFS [4] = '{32'd0, 32'd1, 32'd57, 32'd58};

  localparam longint PI_Q30 = 64'd3373259426;

  typedef logic [FRAC_BITS:0]   cos_w_t;
  typedef cos_w_t               cos_rom_t [ROM_SIZE];
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // sin^2 table by Q30 Taylor series, rounded half up to the fraction format
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint th;
    longint term;
    longint s;
    longint s2;
    for (int k = 0; k < ROM_SIZE; k++) begin
      th   = (PI_Q30 * longint'(k)) >>> (COS_TABLE_BITS + 1);
      term = th;
      s    = th;
      for (int n = 1; n <= 8; n++) begin
        term = (((term * th) >>> 30) * th) >>> 30;
        // series denominator (2n)(2n+1)
        case (n)
          1: term = term / 6;
          2: term = term / 20;
          3: term = term / 42;
          4: term = term / 72;
          5: term = term / 110;
          6: term = term / 156;
          7: term = term / 210;
          default: term = term / 272;
        endcase
        if ((n & 1) == 1) s = s - term;
        else s = s + term;
      end
      if (s < 0) s = 0;
      s2 = (s * s) >>> 30;
      rom[k] = cos_w_t'((s2 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // octave weight: 0.48 per octave, rounded half up
  function automatic cos_w_t amp_of(input int oct);
    longint v;
    v = longint'(ONE_Q);
    for (int i = 0; i < oct; i++) v = (v * 24 + 25) / 50;
    return cos_w_t'(v);
  endfunction

  // a + floor((b - a) * f / 2^FRAC_BITS)
  function automatic val_t blend(input val_t a, input val_t b, input cos_w_t f);
    logic signed [VAL_W:0] diff;
    logic signed [VAL_W+FRAC_BITS+2:0] prod;
    diff = (VAL_W+1)'(b) - (VAL_W+1)'(a);
    prod = (VAL_W+FRAC_BITS+3)'(diff) * $signed({1'b0, f});
    return VAL_W'(a + VAL_W'(prod >>> FRAC_BITS));
  endfunction

endpackage

// ----- hw/rtl/vnth_hash.sv -----
// vnth_hash: four-stage pipelined integer hash of one lattice corner
// into a signed noise value. Depends on vnth_pkg.
module vnth_hash (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       corner_n,
  output vnth_pkg::val_t    value
);
  import vnth_pkg::*;

  logic [31:0] h1_n_r, h2_n_r, h3_n_r;
  logic [31:0] h2_sq_r, h3_t_r;
  val_t        value_r;
  logic [31:0] m_full;
  val_t        value_nxt;

  // final product and mapping to the fraction format
  always_comb begin
    m_full    = h3_n_r * h3_t_r + HASH_ADD2;
    value_nxt = $signed(VAL_W'(ONE_Q) - VAL_W'(m_full[30:30-FRAC_BITS]));
  end

  // scramble, square, polynomial, product
  always_ff @(posedge clk) begin
    if (en) begin
      h1_n_r  <= corner_n ^ (corner_n << HASH_SHIFT);
      h2_n_r  <= h1_n_r;
      h2_sq_r <= h1_n_r * h1_n_r;
      h3_n_r  <= h2_n_r;
      h3_t_r  <= h2_sq_r * HASH_MUL + HASH_ADD1;
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

// ----- hw/rtl/vnth_lattice.sv -----
// vnth_lattice: five-stage front end; world coordinate, lattice cell and
// fraction per octave, and the seeded base corner index. Depends on vnth_pkg.
module vnth_lattice (
  input  logic                                clk,
  input  logic                                en,
  input  logic [vnth_pkg::LOCAL_W-1:0]        local_x,
  input  logic [vnth_pkg::LOCAL_W-1:0]        local_z,
  input  logic signed [vnth_pkg::TILE_W-1:0]  tile_x,
  input  logic signed [vnth_pkg::TILE_W-1:0]  tile_z,
  input  logic [vnth_pkg::SEED_W-1:0]         seed,
  output logic [31:0]                         n0     [vnth_pkg::OCT_N],
  output vnth_pkg::frac_t                     frac_x [vnth_pkg::OCT_N],
  output vnth_pkg::frac_t                     frac_z [vnth_pkg::OCT_N],
  output logic                                neg
);
  import vnth_pkg::*;

  logic signed [WX_W-1:0] world [2];
  logic [WU_W-1:0] wu1_r [2];
  logic [WU_W-1:0] wu2_r [2];
  logic [QW-1:0]   q2_r  [2];
  logic [QW-1:0]   q3_r  [2];
  logic [RW-1:0]   rem3_r [2];
  logic [31:0]     ix4_r [2][OCT_N];
  logic [RW-1:0]   rr4_r [2][OCT_N];
  logic [31:0]     ix_nxt [2][OCT_N];
  logic [RW-1:0]   rr_nxt [2][OCT_N];
  logic [31:0]     n0_r [OCT_N];
  frac_t           frac_r [2][OCT_N];
  logic [4:0]      neg_r;
  logic [P0_W-1:0] prod0 [2];
  logic [WU_W-1:0] rem_full [2];
  logic [PF_W-1:0] prodf [2][OCT_N];
  logic [RW:0]     dbl;
  logic [IX_W-1:0] acc;
  logic [RW-1:0]   r;

  // world coordinate = local + tile * CHUNK_SIZE
  assign world[0] = WX_W'(tile_x) * $signed(WX_W'(CHUNK_SIZE)) + $signed(WX_W'(local_x));
  assign world[1] = WX_W'(tile_z) * $signed(WX_W'(CHUNK_SIZE)) + $signed(WX_W'(local_z));

  // quotient and remainder of the world coordinate by the zoom denominator
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      prod0[ax]    = P0_W'(wu1_r[ax]) * P0_W'(M0);
      rem_full[ax] = wu2_r[ax] - WU_W'(q2_r[ax]) * WU_W'(ZOOM_DEN);
    end
  end

  // doubling per octave: one quotient bit and a new remainder each step
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      r   = rem3_r[ax];
      acc = IX_W'(q3_r[ax]);
      dbl = '0;
      ix_nxt[ax][0] = 32'(acc);
      rr_nxt[ax][0] = r;
      for (int a = 1; a < OCT_N; a++) begin
        dbl = {r, 1'b0};
        if (dbl >= (RW+1)'(ZOOM_DEN)) begin
          dbl = dbl - (RW+1)'(ZOOM_DEN);
          acc = {acc[IX_W-2:0], 1'b1};
        end else begin
          acc = {acc[IX_W-2:0], 1'b0};
        end
        r = RW'(dbl);
        ix_nxt[ax][a] = 32'(acc);
        rr_nxt[ax][a] = r;
      end
    end
  end

  // fraction by reciprocal multiply
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      for (int a = 0; a < OCT_N; a++) begin
        prodf[ax][a] = PF_W'({rr4_r[ax][a], {FRAC_BITS{1'b0}}}) * PF_W'(MF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 2; ax++) begin
        wu1_r[ax]  <= world[ax][WU_W-1:0];
        wu2_r[ax]  <= wu1_r[ax];
        q2_r[ax]   <= QW'(prod0[ax] >> SH0);
        q3_r[ax]   <= q2_r[ax];
        rem3_r[ax] <= RW'(rem_full[ax]);
        for (int a = 0; a < OCT_N; a++) begin
          ix4_r[ax][a]  <= ix_nxt[ax][a];
          rr4_r[ax][a]  <= rr_nxt[ax][a];
          frac_r[ax][a] <= FRAC_BITS'(prodf[ax][a] >> SHF);
        end
      end
      for (int a = 0; a < OCT_N; a++) begin
        n0_r[a] <= ix4_r[0][a] + ix4_r[1][a] * ROW_STRIDE + seed;
      end
      neg_r <= {neg_r[3:0], world[0][WX_W-1] | world[1][WX_W-1]};
    end
  end

  assign n0     = n0_r;
  assign frac_x = frac_r[0];
  assign frac_z = frac_r[1];
  assign neg    = neg_r[4];

endmodule

// ----- hw/rtl/vnth_octave.sv -----
// vnth_octave: one noise octave; four corner hashes, cosine blend in x then z,
// and weighting, seven stages deep. Depends on vnth_pkg and vnth_hash.
module vnth_octave (
  input  logic                          clk,
  input  logic                          en,
  input  logic [31:0]                   n0,
  input  vnth_pkg::frac_t               frac_x,
  input  vnth_pkg::frac_t               frac_z,
  input  vnth_pkg::cos_w_t              amp,
  output logic signed [vnth_pkg::TERM_W-1:0] term
);
  import vnth_pkg::*;

  logic [COS_TABLE_BITS-1:0] idx_x, idx_z;
  cos_w_t wx_p [4];
  cos_w_t wz_p [5];
  val_t   corner_v [4];
  val_t   r1_r, r2_r, r3_r;
  logic signed [TERM_W-1:0] term_r;
  logic signed [2*FRAC_BITS+3:0] wprod;

  // cosine table index: top bits of the fraction
  assign idx_x = COS_TABLE_BITS'({frac_x, {COS_TABLE_BITS{1'b0}}} >> FRAC_BITS);
  assign idx_z = COS_TABLE_BITS'({frac_z, {COS_TABLE_BITS{1'b0}}} >> FRAC_BITS);

  for (genvar c = 0; c < 4; c++) begin : g_corner
    vnth_hash u_hash (
      .clk      (clk),
      .en       (en),
      .corner_n (n0 + CORNER_OFS[c]),
      .value    (corner_v[c])
    );
  end

  assign wprod = (2*FRAC_BITS+4)'(r3_r) * $signed({1'b0, amp});

  // weights follow the hash pipeline, then blend x, blend z, weight
  always_ff @(posedge clk) begin
    if (en) begin
      wx_p[0] <= COS_ROM[idx_x];
      wz_p[0] <= COS_ROM[idx_z];
      for (int i = 1; i < 4; i++) wx_p[i] <= wx_p[i-1];
      for (int i = 1; i < 5; i++) wz_p[i] <= wz_p[i-1];
      r1_r   <= blend(corner_v[0], corner_v[1], wx_p[3]);
      r2_r   <= blend(corner_v[2], corner_v[3], wx_p[3]);
      r3_r   <= blend(r1_r, r2_r, wz_p[4]);
      term_r <= TERM_W'(wprod >>> FRAC_BITS);
    end
  end

  assign term = term_r;

endmodule

// ----- hw/rtl/value_noise_terrain_height.sv -----
// value_noise_terrain_height: top level; config registers, lattice front end,
// one pipeline per octave, sum tree and height scaling. Depends on vnth_pkg,
// vnth_lattice, vnth_octave.
//
//   channel  ports                                   transfer when
//   in       in_valid/in_ready, in_local_*, in_tile_* in_valid & in_ready
//   out      out_valid/out_ready, out_height         out_valid & out_ready
//   cfg      cfg_wr_en, cfg_index, cfg_data          cfg_wr_en
//
// One item per cycle while the output is not held: 5 front end stages, 7 per octave
// (4 hash stages, two blends, weighting), 2 sum stages and the output register.
// All stages advance together; a held output freezes the whole pipeline, so
// nothing is dropped or repeated. Reset clears valid bits and sets seed to 0
// and water level to 64.
module value_noise_terrain_height (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vnth_pkg::LOCAL_W-1:0]        in_local_x,
  input  logic [vnth_pkg::LOCAL_W-1:0]        in_local_z,
  input  logic signed [vnth_pkg::TILE_W-1:0]  in_tile_x,
  input  logic signed [vnth_pkg::TILE_W-1:0]  in_tile_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vnth_pkg::HEIGHT_W-1:0]       out_height,
  input  logic                                cfg_wr_en,
  input  logic [vnth_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vnth_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vnth_pkg::*;

  localparam int LAT_FRONT = 5;
  localparam int LAT_OCT   = 7;
  localparam int LAT_SUM   = 2;
  localparam int LAT_V     = LAT_FRONT + LAT_OCT + LAT_SUM;
  localparam int NEG_D     = LAT_OCT + LAT_SUM;
  localparam int H_W       = TOT_W + 10;

  logic [SEED_W-1:0]  seed_r;
  logic [WATER_W-1:0] water_r;
  logic               en;
  logic [LAT_V-1:0]   vld_r;
  logic [NEG_D-1:0]   neg_r;
  logic               out_valid_r;
  logic [HEIGHT_W-1:0] height_r, height_nxt;

  logic [31:0] n0 [OCT_N];
  frac_t       frac_x [OCT_N];
  frac_t       frac_z [OCT_N];
  logic        neg_front;
  logic signed [TERM_W-1:0] term [OCT_N];
  logic signed [TERM_W-1:0] term_pad [2*NP];
  logic signed [TOT_W-1:0]  pair_r [NP];
  logic signed [TOT_W-1:0]  pair_nxt [NP];
  logic signed [TOT_W-1:0]  total_r, total_nxt;
  logic signed [H_W-1:0]    biased, scaled, hval;

  // whole pipeline advances unless a result is held
  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      water_r <= WATER_W'(64);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SEED:  seed_r  <= cfg_data[SEED_W-1:0];
        REG_WATER: water_r <= cfg_data[WATER_W-1:0];
        default: ;
      endcase
    end
  end

  vnth_lattice u_lattice (
    .clk     (clk),
    .en      (en),
    .local_x (in_local_x),
    .local_z (in_local_z),
    .tile_x  (in_tile_x),
    .tile_z  (in_tile_z),
    .seed    (seed_r),
    .n0      (n0),
    .frac_x  (frac_x),
    .frac_z  (frac_z),
    .neg     (neg_front)
  );

  for (genvar o = 0; o < OCT_N; o++) begin : g_oct
    localparam cos_w_t AMP = amp_of(o);
    vnth_octave u_octave (
      .clk    (clk),
      .en     (en),
      .n0     (n0[o]),
      .frac_x (frac_x[o]),
      .frac_z (frac_z[o]),
      .amp    (AMP),
      .term   (term[o])
    );
  end

  // sum tree: pairs, then the pair sums
  always_comb begin
    for (int j = 0; j < 2 * NP; j++) begin
      term_pad[j] = (j < OCT_N) ? term[j] : '0;
    end
    for (int j = 0; j < NP; j++) begin
      pair_nxt[j] = TOT_W'(term_pad[2*j]) + TOT_W'(term_pad[2*j+1]);
    end
    total_nxt = '0;
    for (int j = 0; j < NP; j++) total_nxt = total_nxt + pair_r[j];
  end

  // height scaling and clamp, or the underwater answer
  always_comb begin
    biased = H_W'(total_r) + H_W'(ONE_Q);
    scaled = biased * $signed(H_W'(water_r));
    hval   = scaled >>> FRAC_BITS;
    if (neg_r[NEG_D-1]) begin
      height_nxt = (water_r == '0) ? '0 : HEIGHT_W'(water_r) - HEIGHT_W'(1);
    end else if (hval < 0) begin
      height_nxt = '0;
    end else if (hval > $signed(H_W'(HEIGHT_MAX))) begin
      height_nxt = HEIGHT_W'(HEIGHT_MAX);
    end else begin
      height_nxt = HEIGHT_W'(hval);
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NP; j++) pair_r[j] <= pair_nxt[j];
      total_r  <= total_nxt;
      neg_r    <= {neg_r[NEG_D-2:0], neg_front};
      height_r <= height_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT_V-2:0], in_valid};
      out_valid_r <= vld_r[LAT_V-1];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_height = height_r;

endmodule
